>>> design/fsg_pkg.sv
`default_nettype none

package fsg_pkg;

  // Field widths.
  localparam int ORDER_BITS = 16;
  localparam int VAL_W      = 16;
  localparam int PRIME_W    = VAL_W + 1;
  localparam int SUM_W      = VAL_W + 1;
  localparam int STEP_CNT_W = $clog2(SUM_W);
  localparam int RANK_W     = 32;

  // Configuration port.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 2;
  localparam logic [APB_ADDR_W-1:0] REG_PRIME = '0;

  localparam logic [PRIME_W-1:0] PRIME_RESET = PRIME_W'(7);

  // Largest order that the 16-bit fields and the order width allow.
  localparam logic [VAL_W-1:0] ORDER_LIMIT = (ORDER_BITS >= VAL_W) ? {VAL_W{1'b1}} :
                                             VAL_W'((64'd1 << ORDER_BITS) - 64'd1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_RUN,
    S_WAIT
  } fsm_state_t;

  // Operands for one step of the walk.
  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [VAL_W-1:0]   order;
    logic [VAL_W-1:0]   cur_num;
    logic [VAL_W-1:0]   cur_den;
    logic [VAL_W-1:0]   nxt_num;
    logic [VAL_W-1:0]   nxt_den;
  } step_req_t;

  // Results of one step of the walk.
  typedef struct packed {
    logic [VAL_W-1:0] new_num;
    logic [VAL_W-1:0] new_den;
    logic [VAL_W-1:0] residue;
  } step_rsp_t;

  // Farey order for a modulus: p - 1, at least one, saturated at the limit.
  function automatic logic [VAL_W-1:0] order_of(input logic [PRIME_W-1:0] p);
    logic [PRIME_W-1:0] n;
    begin
      n = p - PRIME_W'(1);
      if (p < PRIME_W'(2)) begin
        return VAL_W'(1);
      end
      if (n > {1'b0, ORDER_LIMIT}) begin
        return ORDER_LIMIT;
      end
      return n[VAL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/fsg_if.sv
`default_nettype none

// Input channel: one beat per step request.
interface fsg_in_if ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// Output channel: one beat per reached fraction.
interface fsg_out_if import fsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  numerator;
  logic [VAL_W-1:0]  denominator;
  logic [RANK_W-1:0] position;
  logic [VAL_W-1:0]  residue;
  logic              done_res;

  modport source (output valid, output numerator, output denominator, output position,
                  output residue, output done_res, input ready);
  modport sink (input valid, input numerator, input denominator, input position,
                input residue, input done_res, output ready);
endinterface

`default_nettype wire

>>> design/fsg_step_unit.sv
`default_nettype none

// Bit-serial step unit. One bit per cycle, MSB first:
//  - restoring division k = (order + cur_den) / nxt_den, with the quotient
//    bits folded into k*nxt_num and k*nxt_den by shift and add;
//  - residue (prime * nxt_num) mod nxt_den by shift and add over the prime bits.
// Operands must stay stable from start until done.
module fsg_step_unit import fsg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  step_req_t req,
  output logic      done,
  output step_rsp_t rsp
);

  localparam int RES_W = VAL_W + 2;
  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(SUM_W - 1);

  logic                  running;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  done_q;

  logic [SUM_W-1:0]   dvd;
  logic [VAL_W-1:0]   rem;
  logic [SUM_W-1:0]   acc_n;
  logic [SUM_W-1:0]   acc_d;
  logic [PRIME_W-1:0] pbits;
  logic [VAL_W-1:0]   res;
  logic [VAL_W-1:0]   ared;

  logic [SUM_W-1:0]   rtry;
  logic               qbit;
  logic [VAL_W-1:0]   rem_next;
  logic [SUM_W-1:0]   acc_n_next;
  logic [SUM_W-1:0]   acc_d_next;
  logic [RES_W-1:0]   rsum;
  logic [RES_W-1:0]   b_one;
  logic [RES_W-1:0]   b_two;
  logic [VAL_W-1:0]   res_next;
  logic [SUM_W-1:0]   rtry_sub;

  // Division step: bring down the next dividend bit and try the divisor.
  always_comb begin
    rtry     = {rem, dvd[SUM_W-1]};
    rtry_sub = rtry - {1'b0, req.nxt_den};
    qbit     = (rtry >= {1'b0, req.nxt_den});
    rem_next = qbit ? rtry_sub[VAL_W-1:0] : rtry[VAL_W-1:0];
  end

  // Products by the quotient, accumulated MSB first.
  always_comb begin
    acc_n_next = {acc_n[SUM_W-2:0], 1'b0} + (qbit ? {1'b0, req.nxt_num} : SUM_W'(0));
    acc_d_next = {acc_d[SUM_W-2:0], 1'b0} + (qbit ? {1'b0, req.nxt_den} : SUM_W'(0));
  end

  // Residue step: double, add the reduced numerator on a set prime bit, then take off b or 2b.
  always_comb begin
    b_one = {2'b00, req.nxt_den};
    b_two = {1'b0, req.nxt_den, 1'b0};
    rsum  = {1'b0, res, 1'b0} + (pbits[PRIME_W-1] ? {2'b00, ared} : RES_W'(0));
    if (rsum >= b_two) begin
      res_next = VAL_W'(rsum - b_two);
    end else if (rsum >= b_one) begin
      res_next = VAL_W'(rsum - b_one);
    end else begin
      res_next = rsum[VAL_W-1:0];
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= running && (cnt == STEP_LAST);
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + STEP_CNT_W'(1);
        if (cnt == STEP_LAST) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Shift registers and accumulators.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= {1'b0, req.order} + {1'b0, req.cur_den};
      rem   <= '0;
      acc_n <= '0;
      acc_d <= '0;
      pbits <= req.prime;
      res   <= '0;
      ared  <= (req.nxt_num >= req.nxt_den) ? (req.nxt_num - req.nxt_den) : req.nxt_num;
    end else if (running) begin
      dvd   <= {dvd[SUM_W-2:0], 1'b0};
      rem   <= rem_next;
      acc_n <= acc_n_next;
      acc_d <= acc_d_next;
      pbits <= {pbits[PRIME_W-2:0], 1'b0};
      res   <= res_next;
    end
  end

  // Next fraction is k*c - a over k*d - b.
  always_comb begin
    rsp.new_num = VAL_W'(acc_n - {1'b0, req.cur_num});
    rsp.new_den = VAL_W'(acc_d - {1'b0, req.cur_den});
    rsp.residue = res;
  end

  assign done = done_q;

endmodule

`default_nettype wire

>>> design/farey_sequence_generator_core.sv
// A new item is accepted only after the result of the previous one has been loaded.
// The bit-serial divider and residue loop in the step unit take one cycle per bit of
// the 17-bit dividend and modulus.
// A waiting result sits in an output register while the next item is accepted.
// Reset (synchronous, active high): modulus 7, walk at 0/1 with rank zero,
// output register empty.
`default_nettype none

module farey_sequence_generator_core import fsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  fsg_in_if.sink                items,
  fsg_out_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  fsm_state_t state;
  fsm_state_t state_next;

  logic [PRIME_W-1:0] prime;
  logic [VAL_W-1:0]   order;
  logic [VAL_W-1:0]   cur_num;
  logic [VAL_W-1:0]   cur_den;
  logic [VAL_W-1:0]   nxt_num;
  logic [VAL_W-1:0]   nxt_den;
  logic [RANK_W-1:0]  rank;
  logic               finished;

  logic              out_valid;
  logic [VAL_W-1:0]  out_num;
  logic [VAL_W-1:0]  out_den;
  logic [RANK_W-1:0] out_pos;
  logic [VAL_W-1:0]  out_res;
  logic              out_done;

  logic      in_accept;
  logic      cfg_wr;
  logic      walk_restart;
  logic      unit_start;
  logic      unit_done;
  logic      can_load;
  logic      load;
  logic      reach_one;
  step_req_t step_req;
  step_rsp_t step_rsp;

  // Handshake and decode.
  assign in_accept    = items.valid && items.ready;
  assign cfg_wr       = psel && penable && pwrite && pready && (paddr == REG_PRIME);
  assign walk_restart = items.restart || finished || (cur_den == '0) || (nxt_den == '0);
  assign can_load     = !out_valid || results.ready;
  assign reach_one    = (nxt_num == VAL_W'(1)) && (nxt_den == VAL_W'(1));

  // Configuration reads.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PRIME) ? APB_DATA_W'(prime) : '0;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_accept) state_next = S_START;
      S_START: state_next = S_RUN;
      S_RUN: begin
        if (unit_done) begin
          state_next = can_load ? S_IDLE : S_WAIT;
        end
      end
      S_WAIT:  if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    items.ready = 1'b0;
    unit_start  = 1'b0;
    load        = 1'b0;
    unique case (state)
      S_IDLE:  items.ready = 1'b1;
      S_START: unit_start = 1'b1;
      S_RUN:   load = unit_done && can_load;
      S_WAIT:  load = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk state: configuration restart, item restart, then the advance on load.
  always_ff @(posedge clk) begin
    if (rst) begin
      prime    <= PRIME_RESET;
      order    <= order_of(PRIME_RESET);
      cur_num  <= '0;
      cur_den  <= VAL_W'(1);
      nxt_num  <= VAL_W'(1);
      nxt_den  <= order_of(PRIME_RESET);
      rank     <= '0;
      finished <= 1'b0;
    end else if (cfg_wr) begin
      prime    <= pwdata[PRIME_W-1:0];
      order    <= order_of(pwdata[PRIME_W-1:0]);
      cur_num  <= '0;
      cur_den  <= VAL_W'(1);
      nxt_num  <= VAL_W'(1);
      nxt_den  <= order_of(pwdata[PRIME_W-1:0]);
      rank     <= '0;
      finished <= 1'b0;
    end else if (in_accept && walk_restart) begin
      cur_num  <= '0;
      cur_den  <= VAL_W'(1);
      nxt_num  <= VAL_W'(1);
      nxt_den  <= order;
      rank     <= '0;
      finished <= 1'b0;
    end else if (load) begin
      cur_num  <= nxt_num;
      cur_den  <= nxt_den;
      nxt_num  <= step_rsp.new_num;
      nxt_den  <= step_rsp.new_den;
      rank     <= rank + RANK_W'(1);
      finished <= reach_one;
    end
  end

  // Step unit works on the held walk state.
  always_comb begin
    step_req.prime   = prime;
    step_req.order   = order;
    step_req.cur_num = cur_num;
    step_req.cur_den = cur_den;
    step_req.nxt_num = nxt_num;
    step_req.nxt_den = nxt_den;
  end

  fsg_step_unit u_step (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .req   (step_req),
    .done  (unit_done),
    .rsp   (step_rsp)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_num  <= nxt_num;
      out_den  <= nxt_den;
      out_pos  <= rank + RANK_W'(1);
      out_res  <= step_rsp.residue;
      out_done <= reach_one;
    end
  end

  assign results.valid       = out_valid;
  assign results.numerator   = out_num;
  assign results.denominator = out_den;
  assign results.position    = out_pos;
  assign results.residue     = out_res;
  assign results.done_res    = out_done;

  // A modulus write puts the walk back at 0/1 with rank zero.
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (rank == '0 && cur_num == '0 && cur_den == VAL_W'(1) && !finished))
    else $error("walk not restarted after modulus write");

  // The step unit finishes only while the controller waits for it.
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> (state == S_RUN))
    else $error("step unit finished outside of a run");

  // The step unit is started only right after an accepted item.
  a_start_after_accept: assert property (@(posedge clk) disable iff (rst)
    unit_start |-> $past(in_accept))
    else $error("step unit started without an accepted item");

  // Reaching 1/1 flags the result and arms the restart for the next item.
  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    (load && reach_one) |=> (finished && results.done_res))
    else $error("reaching 1/1 not flagged");

endmodule

`default_nettype wire

>>> tb/sv/farey_sequence_generator_core_test.sv
`timescale 1ns / 1ps

module farey_sequence_generator_core_test;
  import fsg_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_BEATS  = 900;

  // One reached fraction as the block should report it.
  typedef struct {
    logic [VAL_W-1:0]  num;
    logic [VAL_W-1:0]  den;
    logic [RANK_W-1:0] pos;
    logic [VAL_W-1:0]  res;
    logic              done;
  } fraction_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fsg_in_if  items_ch ();
  fsg_out_if results_ch ();

  farey_sequence_generator_core uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Fractions predicted but not yet seen on the output channel.
  fraction_t pending_fractions[$];

  // Predicted walk state and modulus.
  logic [PRIME_W-1:0] walk_modulus;
  logic [31:0]        walk_cur_num;
  logic [31:0]        walk_cur_den;
  logic [31:0]        walk_next_num;
  logic [31:0]        walk_next_den;
  logic [31:0]        walk_rank;
  bit                 walk_finished;

  int  mismatches;
  int  cycles;
  int  beats_sent;
  int  beats_checked;
  int  ones_reached;
  int  modulus_writes;
  bit  steady;

  // 20 ns clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d fractions still pending", $time,
               cycles, pending_fractions.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Farey order for a modulus: p - 1, never below one, capped by the field widths.
  function automatic logic [31:0] farey_order(input logic [PRIME_W-1:0] p);
    logic [31:0] cap;
    logic [31:0] n;
    cap = (ORDER_BITS >= 16) ? 32'd65535 : (32'd1 << ORDER_BITS) - 32'd1;
    n = (p < PRIME_W'(2)) ? 32'd1 : 32'(p) - 32'd1;
    if (n > cap) begin
      n = cap;
    end
    return n;
  endfunction

  // Back to 0/1 with rank zero.
  task automatic rewind_walk();
    walk_cur_num  = 32'd0;
    walk_cur_den  = 32'd1;
    walk_next_num = 32'd1;
    walk_next_den = farey_order(walk_modulus);
    walk_rank     = 32'd0;
    walk_finished = 1'b0;
  endtask

  // Advance the predicted walk by one term and return the fraction reached.
  task automatic step_farey(input logic restart, output fraction_t f);
    logic [63:0] n;
    logic [63:0] k;
    logic [63:0] na;
    logic [63:0] nb;
    n = 64'(farey_order(walk_modulus));
    if (restart || walk_finished || walk_next_den == 0 || walk_cur_den == 0) begin
      rewind_walk();
    end
    k  = (n + 64'(walk_cur_den)) / 64'(walk_next_den);
    na = k * 64'(walk_next_num) - 64'(walk_cur_num);
    nb = k * 64'(walk_next_den) - 64'(walk_cur_den);
    walk_cur_num  = walk_next_num;
    walk_cur_den  = walk_next_den;
    walk_next_num = na[31:0];
    walk_next_den = nb[31:0];
    walk_rank     = walk_rank + 32'd1;
    f.done = (walk_cur_num == 32'd1 && walk_cur_den == 32'd1);
    if (f.done) begin
      walk_finished = 1'b1;
    end
    if (walk_cur_den == 0) begin
      f.res = '0;
    end else begin
      f.res = VAL_W'((64'(walk_modulus) * 64'(walk_cur_num)) % 64'(walk_cur_den));
    end
    f.num = walk_cur_num[VAL_W-1:0];
    f.den = walk_cur_den[VAL_W-1:0];
    f.pos = walk_rank;
  endtask

  // Idle length in cycles: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 96) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s wrong, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Compare each result beat with the oldest pending fraction.
  always @(posedge clk) begin : result_check
    fraction_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_fractions.size() == 0) begin
        mismatches++;
        $display("%0t: result beat %0d/%0d with nothing pending", $time,
                 results_ch.numerator, results_ch.denominator);
      end else begin
        want = pending_fractions.pop_front();
        beats_checked++;
        if (want.done) begin
          ones_reached++;
        end
        check_field("numerator", 32'(want.num), 32'(results_ch.numerator));
        check_field("denominator", 32'(want.den), 32'(results_ch.denominator));
        check_field("position", want.pos, results_ch.position);
        check_field("residue", 32'(want.res), 32'(results_ch.residue));
        check_field("done_res", 32'(want.done), 32'(results_ch.done_res));
      end
    end
  end

  // Result side back-pressure.
  initial begin : result_stall
    int n;
    results_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) begin
      @(negedge clk);
    end
    forever begin
      n = gap_len();
      if (n > 0) begin
        results_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      results_ch.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  // Send one input beat; called and returns at a falling edge.
  task automatic send_item(input logic restart);
    int        n;
    fraction_t f;
    n = gap_len();
    if (n > 0) begin
      items_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    items_ch.valid   = 1'b1;
    items_ch.restart = restart;
    @(posedge clk);
    while (!items_ch.ready) begin
      @(posedge clk);
    end
    step_farey(restart, f);
    pending_fractions.push_back(f);
    beats_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted fraction has come out.
  task automatic settle();
    items_ch.valid = 1'b0;
    while (pending_fractions.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic apb_write(input logic [PRIME_W-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_PRIME;
    pwdata  = APB_DATA_W'(v);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    // Writing the modulus also restarts the walk.
    walk_modulus = v;
    rewind_walk();
    modulus_writes++;
    @(negedge clk);
  endtask

  task automatic apb_read_check(input logic [PRIME_W-1:0] v);
    logic [APB_DATA_W-1:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = REG_PRIME;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    got = prdata;
    check_field("prime_modulus readback", APB_DATA_W'(v), got);
    @(negedge clk);
  endtask

  task automatic program_modulus(input logic [PRIME_W-1:0] v);
    apb_write(v);
    apb_read_check(v);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Reset value of the modulus and the first terms of the order-6 walk.
  task automatic test_reset_walk();
    apb_read_check(PRIME_RESET);
    psel    = 1'b0;
    penable = 1'b0;
    repeat (4) send_item(1'b0);
  endtask

  // Restart input in the middle of a walk and twice in a row.
  task automatic test_restart_input();
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b1);
  endtask

  // Moduli below two, a tiny order through 1/1 and past it, saturated
  // orders, and a value that is not prime.
  task automatic test_modulus_extremes();
    settle();
    program_modulus(PRIME_W'(0));
    send_item(1'b0);
    settle();
    program_modulus(PRIME_W'(1));
    send_item(1'b0);
    settle();
    program_modulus(PRIME_W'(2));
    send_item(1'b0);
    settle();
    program_modulus(PRIME_W'(3));
    repeat (3) send_item(1'b0);
    settle();
    program_modulus(PRIME_W'(65536));
    repeat (2) send_item(1'b0);
    settle();
    program_modulus({PRIME_W{1'b1}});
    repeat (2) send_item(1'b0);
    settle();
    program_modulus(PRIME_W'(15));
    repeat (2) send_item(1'b0);
  endtask

  // Long walks under many moduli, mostly small so that 1/1 is reached often,
  // with a rare restart dropped in.
  task automatic test_random_walks();
    int                 small_primes[9] = '{5, 7, 11, 13, 17, 19, 23, 29, 31};
    int                 total;
    int                 phase;
    int                 pick;
    int                 beats;
    logic [PRIME_W-1:0] p;
    total = 0;
    phase = 0;
    while (total < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        p = PRIME_W'($urandom_range(0, 3));
      end else if (pick < 7) begin
        p = PRIME_W'(small_primes[$urandom_range(0, 8)]);
      end else if (pick < 9) begin
        p = PRIME_W'($urandom_range(4, 34));
      end else begin
        p = PRIME_W'($urandom_range(1000, 131071));
      end
      beats = (pick == 9) ? $urandom_range(5, 15) : $urandom_range(60, 180);
      settle();
      program_modulus(p);
      steady = (phase % 4 == 2);
      repeat (beats) send_item($urandom_range(0, 99) < 3);
      total += beats;
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    items_ch.valid   = 1'b0;
    items_ch.restart = 1'b0;
    mismatches       = 0;
    cycles           = 0;
    beats_sent       = 0;
    beats_checked    = 0;
    ones_reached     = 0;
    modulus_writes   = 0;
    steady           = 1'b0;
    walk_modulus     = PRIME_RESET;
    rewind_walk();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_walk();
    test_restart_input();
    test_modulus_extremes();
    test_random_walks();

    // Drain, then give any stray result beat time to show up.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d input beats under %0d modulus writes.", beats_sent, modulus_writes);
    $display("Checked %0d result beats, %0d of them at 1/1.", beats_checked, ones_reached);
    if (mismatches == 0 && pending_fractions.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> farey_sequence_generator_core.f
design/fsg_pkg.sv
design/fsg_if.sv
design/fsg_step_unit.sv
design/farey_sequence_generator_core.sv
tb/sv/farey_sequence_generator_core_test.sv
